// File: sv/cfpa_pkg.sv
package cfpa_pkg;

  localparam int FracBitsDefault    = 16;
  localparam int MaxExponentDefault = 255;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_POW  = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_COMB,
    ST_DIVS,
    ST_DIVQ,
    ST_DIVF,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul_step;
    logic comb;
    logic div_start;
    logic div_step;
    logic div_next_part;
    logic pow_init;
    logic pow_next;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic div_zero;
    logic pow_last;
  } sts_t;

endpackage

// File: sv/cfpa_datapath.sv
module cfpa_datapath
  import cfpa_pkg::*;
#(
  parameter int FRAC_BITS    = FracBitsDefault,
  parameter int MAX_EXPONENT = MaxExponentDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  input  logic [7:0]         exponent_i,
  output logic [2:0]         op_o,
  output logic signed [31:0] res_re_o,
  output logic signed [31:0] res_im_o,
  output logic               overflow_o,
  output logic               divide_by_zero_o
);

  localparam int ExpW = $clog2(MAX_EXPONENT + 1) > 8 ? $clog2(MAX_EXPONENT + 1) : 8;
  localparam logic [ExpW-1:0] ExpCap = ExpW'(MAX_EXPONENT);
  localparam int PW = 64;
  localparam int QW = 33 + FRAC_BITS;
  localparam int NW = PW + FRAC_BITS;
  localparam logic signed [PW+1:0] SatHi = (PW+2)'(64'sh7FFFFFFF);
  localparam logic signed [PW+1:0] SatLo = -(PW+2)'(64'sh80000000);

  logic [2:0]                op_q;
  logic signed [31:0]        ar_q, ai_q, br_q, bi_q;
  logic signed [31:0]        rr_q, ri_q;
  logic [ExpW-1:0]           cnt_q;
  logic                      ov_q, dz_q;
  logic                      den_ph_q;
  logic signed [PW-1:0]      p_q [4];
  logic [1:0]                pidx_q;
  logic signed [31:0]        mx, my;
  logic signed [PW-1:0]      mp;
  // divider state
  logic [PW-1:0]             den_q, rem_q;
  logic [QW-1:0]             quo_q;
  logic [NW-1:0]             num_q;
  logic [6:0]                bit_q;
  logic                      part_q, neg_q;
  logic [PW-1:0]             mag_im_q;
  logic                      neg_im_q;
  logic                      qov_q;

  // select multiplier operands for the current product
  always_comb begin
    mx = '0;
    my = '0;
    if (op_q == OP_POW) begin
      case (pidx_q)
        2'd0: begin mx = rr_q; my = ar_q; end
        2'd1: begin mx = ri_q; my = ai_q; end
        2'd2: begin mx = rr_q; my = ai_q; end
        default: begin mx = ri_q; my = ar_q; end
      endcase
    end else if (op_q == OP_DIV && den_ph_q) begin
      case (pidx_q)
        2'd0: begin mx = br_q; my = br_q; end
        default: begin mx = bi_q; my = bi_q; end
      endcase
    end else begin
      case (pidx_q)
        2'd0: begin mx = ar_q; my = br_q; end
        2'd1: begin mx = ai_q; my = bi_q; end
        2'd2: begin mx = ar_q; my = bi_q; end
        default: begin mx = ai_q; my = br_q; end
      endcase
    end
  end
  assign mp = PW'(mx) * PW'(my);

  // combine products: full sum then floor shift then saturate
  logic signed [PW+1:0] sre, sim, fre, fim;
  logic [PW-1:0]        abs_re, abs_im;
  assign sre = (PW+2)'(p_q[0]) - (PW+2)'(p_q[1]);
  assign sim = (PW+2)'(p_q[2]) + (PW+2)'(p_q[3]);
  assign fre = sre >>> FRAC_BITS;
  assign fim = sim >>> FRAC_BITS;
  // division numerators: re = ar*br + ai*bi, im = ai*br - ar*bi
  logic signed [PW+1:0] nre, nim;
  assign nre = (PW+2)'(p_q[0]) + (PW+2)'(p_q[1]);
  assign nim = (PW+2)'(p_q[3]) - (PW+2)'(p_q[2]);
  assign abs_re = nre[PW+1] ? PW'(-nre) : PW'(nre);
  assign abs_im = nim[PW+1] ? PW'(-nim) : PW'(nim);
  logic [PW:0] den_sum;
  assign den_sum = {1'b0, PW'(p_q[0])} + {1'b0, PW'(p_q[1])};

  function automatic logic signed [31:0] sat(input logic signed [PW+1:0] v,
                                             output logic o);
    o = 1'b0;
    if (v > SatHi) begin o = 1'b1; sat = 32'sh7FFFFFFF; end
    else if (v < SatLo) begin o = 1'b1; sat = 32'sh80000000; end
    else sat = v[31:0];
  endfunction

  // restoring divider step, numerator bits enter from the top of the shifter
  logic [PW:0]   rem_sh;
  logic          q_ge;
  assign rem_sh = {rem_q, num_q[NW-1]};
  assign q_ge   = rem_sh >= {1'b0, den_q};

  logic signed [PW+1:0] qs;
  logic                 o2;
  logic signed [31:0]   v2;
  always_comb begin
    qs = (neg_q ? -(PW+2)'(quo_q) : (PW+2)'(quo_q));
    v2 = sat(qs, o2);
  end

  assign sts_o.div_done = (bit_q == 7'd0);
  assign sts_o.div_zero = (den_sum == '0);
  assign sts_o.pow_last = (cnt_q == '0);

  logic signed [31:0] cr, ci;
  logic co1, co2;
  always_comb begin
    cr = sat(fre, co1);
    ci = sat(fim, co2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= '0;
      ar_q     <= '0;
      ai_q     <= '0;
      br_q     <= '0;
      bi_q     <= '0;
      rr_q     <= '0;
      ri_q     <= '0;
      p_q      <= '{default: '0};
      pidx_q   <= '0;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
      dz_q     <= 1'b0;
      den_ph_q <= 1'b0;
      den_q    <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      num_q    <= '0;
      mag_im_q <= '0;
      neg_im_q <= 1'b0;
      neg_q    <= 1'b0;
      qov_q    <= 1'b0;
      bit_q    <= '0;
      part_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        op_q <= op_i;
        ar_q <= a_re_i; ai_q <= a_im_i; br_q <= b_re_i; bi_q <= b_im_i;
        cnt_q <= (ExpW'(exponent_i) > ExpCap) ? ExpCap : ExpW'(exponent_i);
        pidx_q <= '0;
        ov_q <= 1'b0;
        dz_q <= 1'b0;
        den_ph_q <= (op_i == OP_DIV);
        part_q <= 1'b0;
      end
      if (cmd_i.pow_init) begin
        rr_q <= 32'(64'sd1 <<< FRAC_BITS);
        ri_q <= '0;
      end
      // run one product into the bank
      if (cmd_i.mul_step) begin
        p_q[pidx_q] <= mp;
        pidx_q <= pidx_q + 2'd1;
      end
      // for divide the first pair is br*br and bi*bi: latch the denominator
      if (cmd_i.comb) begin
        if (op_q == OP_DIV) begin
          den_q    <= PW'(den_sum);
          dz_q     <= sts_o.div_zero;
          den_ph_q <= 1'b0;
        end else begin
          rr_q <= cr;
          ri_q <= ci;
          ov_q <= ov_q | co1 | co2;
        end
      end
      if (cmd_i.pow_next) cnt_q <= cnt_q - ExpW'(1);
      if (cmd_i.div_start) begin
        num_q    <= {abs_re, {FRAC_BITS{1'b0}}};
        mag_im_q <= abs_im;
        neg_im_q <= nim[PW+1];
        neg_q    <= nre[PW+1];
        rem_q    <= '0;
        quo_q    <= '0;
        qov_q    <= 1'b0;
        bit_q    <= 7'(PW + FRAC_BITS);
        part_q   <= 1'b0;
      end
      if (cmd_i.div_step) begin
        rem_q <= q_ge ? PW'(rem_sh - {1'b0, den_q}) : PW'(rem_sh);
        quo_q <= {quo_q[QW-2:0], q_ge};
        num_q <= {num_q[NW-2:0], 1'b0};
        if (quo_q[QW-1]) qov_q <= 1'b1;
        bit_q <= bit_q - 7'd1;
      end
      if (cmd_i.div_next_part) begin
        if (part_q) ri_q <= (qov_q | quo_q[QW-1]) ? (neg_q ? 32'sh80000000 : 32'sh7FFFFFFF) : v2;
        else        rr_q <= (qov_q | quo_q[QW-1]) ? (neg_q ? 32'sh80000000 : 32'sh7FFFFFFF) : v2;
        ov_q   <= ov_q | qov_q | quo_q[QW-1] | o2;
        part_q <= 1'b1;
        neg_q  <= neg_im_q;
        num_q  <= {mag_im_q, {FRAC_BITS{1'b0}}};
        rem_q  <= '0;
        quo_q  <= '0;
        qov_q  <= 1'b0;
        bit_q  <= 7'(PW + FRAC_BITS);
      end
    end
  end

  // final result selection
  logic signed [32:0] s_re, s_im;
  always_comb begin
    res_re_o = '0; res_im_o = '0; overflow_o = 1'b0; divide_by_zero_o = 1'b0;
    s_re = '0; s_im = '0;
    case (op_q)
      OP_ADD, OP_SUB: begin
        s_re = (op_q == OP_ADD) ? 33'(ar_q) + 33'(br_q) : 33'(ar_q) - 33'(br_q);
        s_im = (op_q == OP_ADD) ? 33'(ai_q) + 33'(bi_q) : 33'(ai_q) - 33'(bi_q);
        res_re_o = (s_re[32] != s_re[31]) ? (s_re[32] ? 32'sh80000000 : 32'sh7FFFFFFF)
                                          : s_re[31:0];
        res_im_o = (s_im[32] != s_im[31]) ? (s_im[32] ? 32'sh80000000 : 32'sh7FFFFFFF)
                                          : s_im[31:0];
        overflow_o = (s_re[32] != s_re[31]) | (s_im[32] != s_im[31]);
      end
      OP_CONJ: begin
        res_re_o = ar_q;
        res_im_o = (ai_q == 32'sh80000000) ? 32'sh7FFFFFFF : -ai_q;
        overflow_o = (ai_q == 32'sh80000000);
      end
      OP_MUL, OP_POW: begin
        res_re_o = rr_q; res_im_o = ri_q; overflow_o = ov_q;
      end
      OP_DIV: begin
        res_re_o = dz_q ? '0 : rr_q;
        res_im_o = dz_q ? '0 : ri_q;
        overflow_o = dz_q ? 1'b0 : ov_q;
        divide_by_zero_o = dz_q;
      end
      default: ;
    endcase
  end

  assign op_o = op_q;

endmodule

// File: sv/cfpa_ctrl.sv
module cfpa_ctrl
  import cfpa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [2:0] op_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy,
  output logic       done
);

  state_e state_q, state_d;
  logic   div_phase_q, div_phase_d;

  // next state
  always_comb begin
    state_d     = state_q;
    div_phase_d = div_phase_q;
    case (state_q)
      ST_IDLE: if (start) begin
        div_phase_d = 1'b0;
        case (op_i)
          OP_MUL, OP_DIV: state_d = ST_MUL1;
          OP_POW:         state_d = ST_COMB;
          default:        state_d = ST_DONE;
        endcase
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = (op_i == OP_DIV && !div_phase_q) ? ST_COMB : ST_MUL3;
      ST_MUL3: state_d = ST_MUL4;
      ST_MUL4: state_d = (op_i == OP_DIV) ? ST_DIVS : ST_COMB;
      ST_COMB: begin
        if (op_i == OP_DIV) begin
          state_d = sts_i.div_zero ? ST_DONE : ST_MUL1;
          div_phase_d = 1'b1;
        end else if (op_i == OP_POW) state_d = sts_i.pow_last ? ST_DONE : ST_MUL1;
        else state_d = ST_DONE;
      end
      ST_DIVS: state_d = ST_DIVQ;
      ST_DIVQ: if (sts_i.div_done) state_d = ST_DIVF;
      ST_DIVF: state_d = div_phase_q ? ST_DIVQ : ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_DIVF) div_phase_d = 1'b0;
    if (state_q == ST_MUL4) div_phase_d = 1'b1;
  end

  // outputs; for power the first pass through combine only checks and steps the count
  always_comb begin
    cmd_o = '0;
    busy  = (state_q != ST_IDLE);
    done  = (state_q == ST_DONE);
    case (state_q)
      ST_IDLE: begin
        cmd_o.load     = start;
        cmd_o.pow_init = start;
      end
      ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4: cmd_o.mul_step = 1'b1;
      ST_COMB: begin
        cmd_o.comb     = (op_i != OP_POW) || div_phase_q;
        cmd_o.pow_next = (op_i == OP_POW) && !sts_i.pow_last;
      end
      ST_DIVS: cmd_o.div_start = 1'b1;
      ST_DIVQ: begin
        cmd_o.div_step = !sts_i.div_done;
      end
      ST_DIVF: cmd_o.div_next_part = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_phase_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_phase_q <= div_phase_d;
    end
  end

  // a result strobe only ends a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni) done |-> busy)
    else $error("done outside busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done |=> !busy)
    else $error("no return to idle after result");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("item accepted without going busy");

endmodule

// File: sv/complex_fixed_point_alu.sv
// Complex fixed-point ALU, signed Q16.16. Pulse start while busy is low; one
// result follows on done for a single cycle and cannot be stalled, so capture it.
// Add, subtract and conjugate go straight from accept to the result; multiply is set
// by the single shared 32x32 multiplier run four times; power runs one four-product
// pass per step for exponent n (capped at MAX_EXPONENT); divide is set by the
// one-bit-per-cycle restoring divider run for 80 steps on each result part, and
// skips the division when the divisor is zero.
module complex_fixed_point_alu
  import cfpa_pkg::*;
#(
  parameter int FRAC_BITS    = FracBitsDefault,
  parameter int MAX_EXPONENT = MaxExponentDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  input  logic [7:0]         exponent_i,
  output logic signed [31:0] res_re_o,
  output logic signed [31:0] res_im_o,
  output logic               overflow_o,
  output logic               divide_by_zero_o
);

  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] op_held, op_sel;

  // controller sees the new op on the accept cycle, the held op afterwards
  assign op_sel = busy ? op_held : op_i;

  cfpa_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .op_i(op_sel), .sts_i(sts), .cmd_o(cmd), .busy, .done
  );

  cfpa_datapath #(.FRAC_BITS(FRAC_BITS), .MAX_EXPONENT(MAX_EXPONENT)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .op_i, .a_re_i, .a_im_i, .b_re_i,
    .b_im_i, .exponent_i, .op_o(op_held), .res_re_o, .res_im_o, .overflow_o,
    .divide_by_zero_o
  );

endmodule

// File: verif/tb_complex_fixed_point_alu.sv
`timescale 1ns / 100ps

module tb_complex_fixed_point_alu;
  import cfpa_pkg::*;

  localparam int FracBits = FracBitsDefault;
  localparam int MaxExp   = MaxExponentDefault;
  localparam longint Max32 = 64'sd2147483647;
  localparam longint Min32 = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               ovf;
    logic               dbz;
  } cplx_res_t;

  // Saturate to 32 bits, noting any clipping
  function automatic longint clip32(input longint v, inout bit ovf);
    if (v > Max32) begin
      ovf = 1;
      return Max32;
    end
    if (v < Min32) begin
      ovf = 1;
      return Min32;
    end
    return v;
  endfunction

  // floor((x1*y1 +/- x2*y2) / 2^FracBits) at full width
  function automatic longint fix_prod(input longint x1, input longint y1,
                                      input longint x2, input longint y2, input bit sub);
    logic signed [127:0] s;
    s = sub ? (128'(x1) * 128'(y1) - 128'(x2) * 128'(y2))
            : (128'(x1) * 128'(y1) + 128'(x2) * 128'(y2));
    s = s >>> FracBits;
    return longint'(s);
  endfunction

  // Truncated num * 2^FracBits / den, saturated
  function automatic longint fix_quot(input logic signed [127:0] num,
                                      input logic signed [127:0] den, inout bit ovf);
    logic signed [127:0] q;
    bit neg;
    neg = num < 0;
    q = (neg ? -num : num) << FracBits;
    q = q / den;
    if (q > 128'sd4294967296) q = 128'sd4294967296;
    return clip32(neg ? -longint'(q) : longint'(q), ovf);
  endfunction

  function automatic cplx_res_t alu_predict(input logic [2:0] op,
      input longint ar, input longint ai, input longint br, input longint bi,
      input int n);
    cplx_res_t r;
    bit ovf;
    longint rr, ri, tr, ti;
    logic signed [127:0] den;
    ovf = 0;
    rr = 0;
    ri = 0;
    r.dbz = 0;
    case (op)
      OP_ADD: begin
        rr = clip32(ar + br, ovf);
        ri = clip32(ai + bi, ovf);
      end
      OP_SUB: begin
        rr = clip32(ar - br, ovf);
        ri = clip32(ai - bi, ovf);
      end
      OP_MUL: begin
        rr = clip32(fix_prod(ar, br, ai, bi, 1), ovf);
        ri = clip32(fix_prod(ar, bi, ai, br, 0), ovf);
      end
      OP_DIV: begin
        den = 128'(br) * 128'(br) + 128'(bi) * 128'(bi);
        if (den == 0) r.dbz = 1;
        else begin
          rr = fix_quot(128'(ar) * 128'(br) + 128'(ai) * 128'(bi), den, ovf);
          ri = fix_quot(128'(ai) * 128'(br) - 128'(ar) * 128'(bi), den, ovf);
        end
      end
      OP_CONJ: begin
        rr = ar;
        ri = clip32(-ai, ovf);
      end
      OP_POW: begin
        if (n > MaxExp) n = MaxExp;
        rr = longint'(1) << FracBits;
        for (int k = 0; k < n; k++) begin
          tr = clip32(fix_prod(rr, ar, ri, ai, 1), ovf);
          ti = clip32(fix_prod(rr, ai, ri, ar, 0), ovf);
          rr = tr;
          ri = ti;
        end
      end
      default: ;
    endcase
    r.re  = rr[31:0];
    r.im  = ri[31:0];
    r.ovf = ovf;
    return r;
  endfunction

  class alu_scoreboard;
    cplx_res_t pending_q[$];
    int        errors;

    function void note_item(input logic [2:0] op, input logic signed [31:0] ar,
        input logic signed [31:0] ai, input logic signed [31:0] br,
        input logic signed [31:0] bi, input logic [7:0] n);
      pending_q.push_back(alu_predict(op, ar, ai, br, bi, n));
    endfunction

    function void check_result(input cplx_res_t got);
      cplx_res_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h", $time, got.re, got.im);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.re !== exp_r.re) begin
        $display("%0t: res_re expected %h actual %h", $time, exp_r.re, got.re);
        errors++;
      end
      if (got.im !== exp_r.im) begin
        $display("%0t: res_im expected %h actual %h", $time, exp_r.im, got.im);
        errors++;
      end
      if (got.ovf !== exp_r.ovf) begin
        $display("%0t: overflow expected %b actual %b", $time, exp_r.ovf, got.ovf);
        errors++;
      end
      if (got.dbz !== exp_r.dbz) begin
        $display("%0t: divide_by_zero expected %b actual %b", $time, exp_r.dbz, got.dbz);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               start = 0;
  logic               busy, done;
  logic [2:0]         op_i = '0;
  logic signed [31:0] a_re_i = '0, a_im_i = '0, b_re_i = '0, b_im_i = '0;
  logic [7:0]         exponent_i = '0;
  logic signed [31:0] res_re_o, res_im_o;
  logic               overflow_o, divide_by_zero_o;

  alu_scoreboard sb = new();
  bit            calm;

  complex_fixed_point_alu u_dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Check every strobed result
  always @(posedge clk_i) begin
    cplx_res_t got;
    if (rst_ni && done) begin
      got.re  = res_re_o;
      got.im  = res_im_o;
      got.ovf = overflow_o;
      got.dbz = divide_by_zero_o;
      sb.check_result(got);
    end
  end

  // Hold an item until the block takes it, then note it
  task automatic send_item(input logic [2:0] op, input logic [31:0] ar,
      input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi,
      input logic [7:0] n);
    while (!calm && $urandom_range(99) < 20) begin
      start <= 0;
      @(negedge clk_i);
    end
    start      <= 1;
    op_i       <= op;
    a_re_i     <= ar;
    a_im_i     <= ai;
    b_re_i     <= br;
    b_im_i     <= bi;
    exponent_i <= n;
    do @(posedge clk_i); while (busy);
    sb.note_item(op, ar, ai, br, bi, n);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_part();
    case ($urandom_range(5))
      0: return 32'h7fffffff - $urandom_range(2);
      1: return 32'h80000000 + $urandom_range(2);
      2: return $urandom_range(1) ? 32'($urandom_range(131072)) : -32'($urandom_range(131072));
      3: return $urandom_range(1) ? 32'($urandom_range(8)) : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [2:0] op;
    logic [7:0] n;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // Directed: extremes, every op, saturation, zero divisor, exponent edges
    send_item(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff, 0);
    send_item(OP_ADD, 32'hffffffff, 32'h0, 32'hffffffff, 32'h7fffffff, 8'hff);
    send_item(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff, 0);
    send_item(OP_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0);
    send_item(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_item(OP_MUL, 32'hffffffff, 32'h1, 32'h1, 32'hffffffff, 0);
    send_item(OP_DIV, 32'h10000, 32'h20000, 32'h0, 32'h0, 0);
    send_item(OP_DIV, 32'h7fffffff, 32'h80000000, 32'h1, 32'h0, 0);
    send_item(OP_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_item(OP_DIV, 32'h30000, 32'hfffd0000, 32'h10000, 32'h10000, 0);
    send_item(OP_CONJ, 32'h12345678, 32'h80000000, 0, 0, 0);
    send_item(OP_CONJ, 32'h80000000, 32'h7fffffff, 0, 0, 0);
    send_item(OP_POW, 32'h20000, 32'h0, 0, 0, 0);
    send_item(OP_POW, 32'h10000, 32'h10000, 0, 0, 8);
    send_item(OP_POW, 32'h20000, 32'h10000, 0, 0, 40);
    send_item(OP_POW, 32'h0ff00, 32'h00100, 0, 0, 8'hff);
    send_item(3'd6, 32'h1, 32'h1, 32'h1, 32'h1, 1);
    send_item(3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 8'hff);
    // Random items; a stretch in the middle runs without gaps
    for (int i = 0; i < 1600; i++) begin
      calm = (i >= 700 && i < 900);
      op = $urandom_range(99) < 5 ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      n  = $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(6));
      send_item(op, rand_part(), rand_part(), rand_part(), rand_part(), n);
    end
    calm = 0;
    start <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
